FILE: rtl/lpc_rwm_pkg.sv
// Package for the LPC residual window measure block.
// Holds the window geometry, field widths, mode and kind codes, the filter taps
// and the sample clamp. It depends on nothing else.
package lpc_rwm_pkg;

    // Window geometry
    localparam int WINDOW_DEPTH = 1024;
    localparam int IDX_W        = $clog2(WINDOW_DEPTH);
    localparam int POS_W        = $clog2(WINDOW_DEPTH + 1);

    // Field widths
    localparam int SAMPLE_W      = 24;
    localparam int INDEX_FIELD_W = 11;
    localparam int MEASURE_W     = 60;
    localparam int CMP_W         = (POS_W > INDEX_FIELD_W) ? POS_W : INDEX_FIELD_W;
    localparam int S_TDATA_W     = 48;
    localparam int M_TDATA_W     = 64;

    // Arithmetic widths
    localparam int TAP_COUNT = 6;
    localparam int TAP_W     = 3;
    localparam int COEF_W    = 14;
    localparam int PROD_W    = 2 * SAMPLE_W;
    localparam int RES_W     = PROD_W + 1;

    localparam logic [MEASURE_W-1:0] MEASURE_MAX = {MEASURE_W{1'b1}};

    // Sample width modes
    localparam logic [1:0] MODE_8  = 2'd0;
    localparam logic [1:0] MODE_16 = 2'd1;
    localparam logic [1:0] MODE_24 = 2'd2;

    // Input word kinds
    localparam logic KIND_PUSH    = 1'b0;
    localparam logic KIND_MEASURE = 1'b1;

    // Q2.12 inverse filter taps.
    function automatic logic signed [COEF_W-1:0] tap_coef(input logic [TAP_W-1:0] k);
        logic signed [COEF_W-1:0] c;
        begin
            case (k)
                3'd0:    c = 14'sd4096;
                3'd1:    c = -14'sd7127;
                3'd2:    c = 14'sd6431;
                3'd3:    c = -14'sd5202;
                3'd4:    c = 14'sd2990;
                3'd5:    c = -14'sd983;
                default: c = 14'sd0;
            endcase
            return c;
        end
    endfunction

    // Saturate a pushed sample to the width of the current mode.
    function automatic logic signed [SAMPLE_W-1:0] clamp_to_mode(
        input logic signed [SAMPLE_W-1:0] s,
        input logic [1:0]                 mode
    );
        logic signed [SAMPLE_W-1:0] r;
        begin
            r = s;
            if (mode == MODE_8) begin
                if (s > 24'sd127) r = 24'sd127;
                else if (s < -24'sd128) r = -24'sd128;
            end
            else if (mode == MODE_16) begin
                if (s > 24'sd32767) r = 24'sd32767;
                else if (s < -24'sd32768) r = -24'sd32768;
            end
            return r;
        end
    endfunction

endpackage

FILE: rtl/lpc_residual_window_measure.sv
// Top level of the LPC residual window measure; uses lpc_rwm_pkg.
// Pushes give no result and run one per cycle while no measure is running. A measure over
// n positions issues the shared multiplier n times in the 8/24-bit modes, or sum of
// min(6, i+1) times in the 16-bit mode; each product passes the read, product and residual
// registers into the accumulator; a bad or empty range goes straight to done. The input stalls until
// the result is loaded. Reset sets 16-bit mode; a fill count makes unwritten entries read zero.
module lpc_residual_window_measure (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // sample[23:0], start_index[34:24], stop_index[45:35], zero pad[47:46]
    input  logic [lpc_rwm_pkg::S_TDATA_W-1:0]   s_tdata,
    // kind[0]
    input  logic [0:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // measure[59:0], zero pad[63:60]
    output logic [lpc_rwm_pkg::M_TDATA_W-1:0]   m_tdata,
    // range_error[0]
    output logic [0:0]                          m_tuser,
    input  logic                                cfg_wr_en,
    input  logic [1:0]                          cfg_wr_data
);

    localparam int DEPTH     = lpc_rwm_pkg::WINDOW_DEPTH;
    localparam int IDX_W     = lpc_rwm_pkg::IDX_W;
    localparam int POS_W     = lpc_rwm_pkg::POS_W;
    localparam int CMP_W     = lpc_rwm_pkg::CMP_W;
    localparam int SAMPLE_W  = lpc_rwm_pkg::SAMPLE_W;
    localparam int FIELD_W   = lpc_rwm_pkg::INDEX_FIELD_W;
    localparam int MEASURE_W = lpc_rwm_pkg::MEASURE_W;
    localparam int TAP_W     = lpc_rwm_pkg::TAP_W;
    localparam int PROD_W    = lpc_rwm_pkg::PROD_W;
    localparam int RES_W     = lpc_rwm_pkg::RES_W;
    localparam int M_TDATA_W = lpc_rwm_pkg::M_TDATA_W;

    localparam logic [TAP_W-1:0] TAP_LAST = TAP_W'(lpc_rwm_pkg::TAP_COUNT - 1);

    // Sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    // Sample store
    logic signed [SAMPLE_W-1:0] mem [DEPTH];

    // Control registers
    logic [1:0]           state_reg;
    logic [1:0]           mode_reg;
    logic [IDX_W-1:0]     oldest_reg;
    logic [IDX_W-1:0]     oldest_next;
    logic [POS_W-1:0]     fill_reg;
    logic [POS_W-1:0]     pos_reg;
    logic [POS_W-1:0]     stop_reg;
    logic [TAP_W-1:0]     tap_reg;
    logic                 err_reg;
    logic [MEASURE_W-1:0] acc_reg;
    logic [MEASURE_W-1:0] acc_next;
    logic signed [RES_W-1:0] res_reg;
    logic                 out_valid_reg;
    logic [MEASURE_W-1:0] out_data_reg;
    logic                 out_err_reg;

    // Pipeline registers
    logic                       a_valid_reg;
    logic                       a_ok_reg;
    logic [TAP_W-1:0]           a_tap_reg;
    logic                       a_last_tap_reg;
    logic                       a_last_all_reg;
    logic signed [SAMPLE_W-1:0] rd_data_reg;
    logic                       b_valid_reg;
    logic                       b_last_tap_reg;
    logic                       b_last_all_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   prod_next;
    logic                       c_valid_reg;
    logic                       c_last_all_reg;
    logic [RES_W-2:0]           res_abs_reg;

    // Combinational signals
    logic                       in_fire;
    logic                       push_fire;
    logic                       meas_fire;
    logic signed [SAMPLE_W-1:0] in_sample;
    logic [CMP_W-1:0]           in_start;
    logic [CMP_W-1:0]           in_stop;
    logic                       bad_range;
    logic                       out_free;
    logic                       mode_res;
    logic                       issue;
    logic [POS_W-1:0]           tap_ext;
    logic [POS_W-1:0]           pos_rel;
    logic [IDX_W:0]             phys_sum;
    logic [IDX_W:0]             phys_wrap;
    logic [IDX_W-1:0]           rd_addr;
    logic                       rd_ok;
    logic                       tap_last;
    logic [POS_W-1:0]           pos_inc;
    logic                       all_last;
    logic signed [SAMPLE_W-1:0] op_a;
    logic signed [SAMPLE_W-1:0] op_b;
    logic signed [RES_W-1:0]    res_sum;
    logic signed [RES_W-1:0]    res_mag;
    logic [MEASURE_W:0]         acc_sum;

    // Input word decode and handshake
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign push_fire = in_fire && (s_tuser[0] == lpc_rwm_pkg::KIND_PUSH);
    assign meas_fire = in_fire && (s_tuser[0] == lpc_rwm_pkg::KIND_MEASURE);
    assign in_sample = s_tdata[SAMPLE_W-1:0];
    assign in_start  = CMP_W'(s_tdata[SAMPLE_W+FIELD_W-1:SAMPLE_W]);
    assign in_stop   = CMP_W'(s_tdata[SAMPLE_W+2*FIELD_W-1:SAMPLE_W+FIELD_W]);
    assign bad_range = (in_start > in_stop) || (in_stop > CMP_W'(DEPTH));
    assign out_free  = !out_valid_reg || m_tready;
    assign mode_res  = (mode_reg == lpc_rwm_pkg::MODE_16);

    // Window pointer advance on a push
    assign oldest_next = (oldest_reg == IDX_W'(DEPTH - 1)) ? '0 : oldest_reg + 1'b1;

    // Read address generation: position pos - tap, relative to the oldest entry
    assign issue     = (state_reg == ST_RUN);
    assign tap_ext   = POS_W'(tap_reg);
    assign pos_rel   = pos_reg - tap_ext;
    assign phys_sum  = {1'b0, oldest_reg} + (IDX_W+1)'(pos_rel);
    assign phys_wrap = (phys_sum >= (IDX_W+1)'(DEPTH)) ? phys_sum - (IDX_W+1)'(DEPTH)
                                                       : phys_sum;
    assign rd_addr   = phys_wrap[IDX_W-1:0];
    assign rd_ok     = (fill_reg == POS_W'(DEPTH)) || (POS_W'(rd_addr) < fill_reg);

    // Tap stepping: residual mode walks taps until the last tap or position 0, else one read
    assign tap_last  = mode_res ? ((tap_reg == TAP_LAST) || (tap_ext == pos_reg)) : 1'b1;
    assign pos_inc   = pos_reg + 1'b1;
    assign all_last  = tap_last && (pos_inc == stop_reg);

    // Shared multiplier: tap times sample, or sample squared
    assign op_a      = a_ok_reg ? rd_data_reg : '0;
    assign op_b      = mode_res ? SAMPLE_W'(lpc_rwm_pkg::tap_coef(a_tap_reg)) : op_a;
    assign prod_next = op_a * op_b;

    // Residual accumulation and magnitude
    assign res_sum   = res_reg + RES_W'(prod_reg);
    assign res_mag   = res_sum[RES_W-1] ? -res_sum : res_sum;

    // Saturating measure sum
    assign acc_sum   = {1'b0, acc_reg} + (MEASURE_W+1)'(res_abs_reg);
    assign acc_next  = acc_sum[MEASURE_W] ? lpc_rwm_pkg::MEASURE_MAX : acc_sum[MEASURE_W-1:0];

    // Sample store: write on push, registered read each cycle
    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            mem[oldest_reg] <= lpc_rwm_pkg::clamp_to_mode(in_sample, mode_reg);
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Pipeline payload and tags
    always_ff @(posedge clk)
    begin
        a_ok_reg       <= rd_ok;
        a_tap_reg      <= tap_reg;
        a_last_tap_reg <= tap_last;
        a_last_all_reg <= all_last;
        b_last_tap_reg <= a_last_tap_reg;
        b_last_all_reg <= a_last_all_reg;
        prod_reg       <= prod_next;
        c_last_all_reg <= b_last_all_reg;
        res_abs_reg    <= res_mag[RES_W-2:0];
    end

    // Sequencer, window pointers, accumulators and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= lpc_rwm_pkg::MODE_16;
            oldest_reg    <= '0;
            fill_reg      <= '0;
            pos_reg       <= '0;
            stop_reg      <= '0;
            tap_reg       <= '0;
            err_reg       <= 1'b0;
            acc_reg       <= '0;
            res_reg       <= '0;
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_err_reg   <= 1'b0;
        end
        else
        begin
            // Configuration write
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end

            // Push bookkeeping
            if (push_fire)
            begin
                oldest_reg <= oldest_next;
                if (fill_reg != POS_W'(DEPTH))
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end

            // Pipeline valid flags
            a_valid_reg <= issue;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg && b_last_tap_reg;

            // Residual sum clears after the last tap of each position
            if (b_valid_reg)
            begin
                res_reg <= b_last_tap_reg ? '0 : res_sum;
            end

            // Measure sum
            if (meas_fire)
            begin
                acc_reg <= '0;
                res_reg <= '0;
            end
            else if (c_valid_reg)
            begin
                acc_reg <= acc_next;
            end

            // Output register: load a finished measure, else drop a taken word
            if ((state_reg == ST_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= acc_reg;
                out_err_reg   <= err_reg;
            end
            else if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            // Sequencer
            case (state_reg)
                ST_IDLE:
                begin
                    if (meas_fire)
                    begin
                        err_reg  <= bad_range;
                        pos_reg  <= POS_W'(in_start);
                        stop_reg <= POS_W'(in_stop);
                        tap_reg  <= '0;
                        if (bad_range || (in_start == in_stop))
                        begin
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            state_reg <= ST_RUN;
                        end
                    end
                end
                ST_RUN:
                begin
                    if (tap_last)
                    begin
                        tap_reg <= '0;
                        pos_reg <= pos_inc;
                        if (pos_inc == stop_reg)
                        begin
                            state_reg <= ST_DRAIN;
                        end
                    end
                    else
                    begin
                        tap_reg <= tap_reg + 1'b1;
                    end
                end
                ST_DRAIN:
                begin
                    if (c_valid_reg && c_last_all_reg)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Output ports
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_data_reg);
    assign m_tuser  = out_err_reg;

endmodule

FILE: rtl/lpc_rwm_checker.sv
// Port-level checker for the LPC residual window measure block, with its bind.
// Uses lpc_rwm_pkg for port widths; watches the top level's ports only.
module lpc_rwm_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [lpc_rwm_pkg::S_TDATA_W-1:0] s_tdata,
    input logic [0:0]                        s_tuser,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [lpc_rwm_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [0:0]                        m_tuser,
    input logic                              cfg_wr_en,
    input logic [1:0]                        cfg_wr_data
);

    // A stalled result word holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

    // A range error always reports a zero measure.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
    else $error("range error with nonzero measure");

    // The measure never uses the pad bits of the result word.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[lpc_rwm_pkg::M_TDATA_W-1:lpc_rwm_pkg::MEASURE_W] == '0)
    else $error("measure exceeds its width");

    // A taken measure word lowers the input's ready.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser[0] |=> !s_tready)
    else $error("input taken during a measure");

endmodule

bind lpc_residual_window_measure lpc_rwm_checker u_lpc_rwm_checker (.*);

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for lpc_residual_window_measure: streams push and measure words
// through the block and compares each result word against an in-bench window predictor.
// Depends on lpc_rwm_pkg and the RTL top level only.
module testbench;

    localparam int WINDOW_DEPTH  = lpc_rwm_pkg::WINDOW_DEPTH;
    localparam int IDX_W         = lpc_rwm_pkg::IDX_W;
    localparam int SAMPLE_W      = lpc_rwm_pkg::SAMPLE_W;
    localparam int INDEX_FIELD_W = lpc_rwm_pkg::INDEX_FIELD_W;
    localparam int MEASURE_W     = lpc_rwm_pkg::MEASURE_W;
    localparam int S_TDATA_W     = lpc_rwm_pkg::S_TDATA_W;
    localparam int M_TDATA_W     = lpc_rwm_pkg::M_TDATA_W;
    localparam int TAP_COUNT     = lpc_rwm_pkg::TAP_COUNT;

    // The unused mode code, which behaves as the 24-bit mode.
    localparam logic [1:0] MODE_SPARE = 2'd3;

    typedef struct {
        logic [MEASURE_W-1:0] measure;
        logic                 range_error;
    } measure_result_t;

    localparam logic [63:0] MEASURE_CEIL = 64'(lpc_rwm_pkg::MEASURE_MAX);
    localparam int          TAIL_CYCLES  = 8;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [S_TDATA_W-1:0]       s_tdata = '0;
    logic [0:0]                 s_tuser = '0;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [M_TDATA_W-1:0]       m_tdata;
    logic [0:0]                 m_tuser;
    logic                       cfg_wr_en = 1'b0;
    logic [1:0]                 cfg_wr_data = '0;

    // Predictor state: its own copy of the window, the oldest slot and the mode.
    logic signed [SAMPLE_W-1:0] window_store [WINDOW_DEPTH];
    logic [IDX_W-1:0]           oldest_slot;
    logic [1:0]                 mode_shadow;
    measure_result_t            pending_measures [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int fail_count = 0;
    int push_count = 0;
    int measure_count = 0;
    int bad_range_count = 0;
    int checked_count = 0;

    lpc_residual_window_measure dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Free-running clock, 8 ns period.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Q2.12 inverse filter taps.
    function automatic longint lpc_tap(input int unsigned k);
        case (k)
            0: return 4096;
            1: return -7127;
            2: return 6431;
            3: return -5202;
            4: return 2990;
            5: return -983;
            default: return 0;
        endcase
    endfunction

    // Saturate a pushed sample to the sample width of the given mode.
    function automatic logic signed [SAMPLE_W-1:0] fit_to_mode(
        input logic signed [SAMPLE_W-1:0] s,
        input logic [1:0]                 m
    );
        longint lim;
        longint v;
        v = s;
        case (m)
            lpc_rwm_pkg::MODE_8:  lim = 127;
            lpc_rwm_pkg::MODE_16: lim = 32767;
            default:              lim = 8388607;
        endcase
        if (v > lim)
            v = lim;
        else if (v < -lim - 1)
            v = -lim - 1;
        return v[SAMPLE_W-1:0];
    endfunction

    function automatic longint window_sample(input int unsigned pos);
        return longint'(window_store[IDX_W'((oldest_slot + pos) % WINDOW_DEPTH)]);
    endfunction

    // Absolute filter residual at one position; taps before position 0 drop out.
    function automatic logic [63:0] residual_magnitude(input int unsigned pos);
        longint acc;
        acc = 0;
        for (int unsigned k = 0; k < TAP_COUNT && k <= pos; k++)
            acc += lpc_tap(k) * window_sample(pos - k);
        return (acc < 0) ? 64'(-acc) : 64'(acc);
    endfunction

    // Saturating sum over [first, last): residuals in 16-bit mode, squares otherwise.
    function automatic logic [63:0] predict_measure(input int unsigned first,
                                                    input int unsigned last);
        logic [63:0] total;
        logic [63:0] term;
        longint      s;
        total = '0;
        for (int unsigned pos = first; pos < last; pos++)
        begin
            if (mode_shadow == lpc_rwm_pkg::MODE_16)
                term = residual_magnitude(pos);
            else
            begin
                s = window_sample(pos);
                term = 64'(s * s);
            end
            if (term > MEASURE_CEIL - total)
                total = MEASURE_CEIL;
            else
                total = total + term;
        end
        return total;
    endfunction

    // Result checker and receiver stall generator.
    always @(posedge clk)
    begin : result_check
        measure_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            checked_count++;
            if (pending_measures.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected result word, measure %h error %b",
                         $time, m_tdata[MEASURE_W-1:0], m_tuser[0]);
            end
            else
            begin
                want = pending_measures.pop_front();
                if (m_tdata[MEASURE_W-1:0] !== want.measure)
                begin
                    fail_count++;
                    $display("%0t: measure mismatch, expected %h actual %h",
                             $time, want.measure, m_tdata[MEASURE_W-1:0]);
                end
                if (m_tuser[0] !== want.range_error)
                begin
                    fail_count++;
                    $display("%0t: range_error mismatch, expected %b actual %b",
                             $time, want.range_error, m_tuser[0]);
                end
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Send one word, with random idle cycles ahead of it, and update the predictor
    // at the edge where it is taken. tvalid stays high afterwards.
    task automatic send_word(input logic                     kind,
                             input logic [SAMPLE_W-1:0]      smp,
                             input logic [INDEX_FIELD_W-1:0] st,
                             input logic [INDEX_FIELD_W-1:0] sp);
        measure_result_t want;
        logic [63:0]     total;
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {2'b00, sp, st, smp};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (kind == lpc_rwm_pkg::KIND_PUSH)
        begin
            window_store[oldest_slot] = fit_to_mode(smp, mode_shadow);
            oldest_slot = IDX_W'((oldest_slot + 1) % WINDOW_DEPTH);
            push_count++;
        end
        else
        begin
            measure_count++;
            if (st > sp || sp > WINDOW_DEPTH)
            begin
                want.measure = '0;
                want.range_error = 1'b1;
                bad_range_count++;
            end
            else
            begin
                total = predict_measure(32'(st), 32'(sp));
                want.measure = total[MEASURE_W-1:0];
                want.range_error = 1'b0;
            end
            pending_measures.push_back(want);
        end
    endtask

    task automatic push_sample(input logic [SAMPLE_W-1:0] smp);
        send_word(lpc_rwm_pkg::KIND_PUSH, smp, INDEX_FIELD_W'($urandom()),
                  INDEX_FIELD_W'($urandom()));
    endtask

    task automatic measure_range(input logic [INDEX_FIELD_W-1:0] st,
                                 input logic [INDEX_FIELD_W-1:0] sp);
        send_word(lpc_rwm_pkg::KIND_MEASURE, SAMPLE_W'($urandom()), st, sp);
    endtask

    // Stop sending and wait until every expected result has come, plus a short tail.
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (pending_measures.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_word_mode(input logic [1:0] m);
        wait_for_drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        mode_shadow = m;
        cfg_wr_en   <= 1'b0;
    endtask

    // Empty, bad and full ranges over the cleared window in the reset mode.
    task automatic test_range_rules();
        measure_range(11'd0, 11'd1024);
        measure_range(11'd0, 11'd0);
        measure_range(11'd1024, 11'd1024);
        measure_range(11'd7, 11'd6);
        measure_range(11'd0, 11'd1025);
        measure_range(11'd2047, 11'd2047);
        measure_range(11'd1024, 11'd0);
    endtask

    // Sample extremes, saturation per mode, stored samples kept across mode changes,
    // and the unused mode acting as the 24-bit mode.
    task automatic test_sample_extremes();
        write_word_mode(lpc_rwm_pkg::MODE_24);
        push_sample(24'h7FFFFF);
        push_sample(24'h800000);
        push_sample(24'hFFFFFF);
        push_sample(24'h000000);
        push_sample(24'h000001);
        push_sample(24'h7FFFFF);
        measure_range(11'd1018, 11'd1024);
        write_word_mode(lpc_rwm_pkg::MODE_16);
        measure_range(11'd1018, 11'd1024);
        push_sample(24'h7FFFFF);
        push_sample(24'h800000);
        measure_range(11'd1016, 11'd1024);
        write_word_mode(lpc_rwm_pkg::MODE_8);
        push_sample(24'h7FFFFF);
        push_sample(24'h800000);
        measure_range(11'd1014, 11'd1024);
        write_word_mode(MODE_SPARE);
        measure_range(11'd0, 11'd1024);
    endtask

    // Random traffic in batches; each batch starts with a fresh mode written while idle.
    task automatic test_random_traffic(input int items, input int send_pct,
                                       input int recv_pct);
        int unsigned st;
        int unsigned sp;
        int unsigned pick;
        logic [SAMPLE_W-1:0] smp;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int n = 0; n < items; n++)
        begin
            if (n % 85 == 0)
                write_word_mode(2'($urandom_range(3)));
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                // Push: full-range values, values around the mode limits, or rails.
                pick = $urandom_range(99);
                if (pick < 15)
                    smp = $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
                else if (pick < 40)
                    smp = 24'($signed($urandom_range(80000)) - 40000);
                else
                    smp = SAMPLE_W'($urandom());
                push_sample(smp);
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 70)
                begin
                    st = $urandom_range(WINDOW_DEPTH);
                    sp = st + $urandom_range(24);
                end
                else if (pick < 82)
                begin
                    // Ranges at the oldest end, where taps drop out.
                    st = $urandom_range(5);
                    sp = st + $urandom_range(12);
                end
                else if (pick < 85)
                begin
                    st = $urandom_range(8);
                    sp = WINDOW_DEPTH - $urandom_range(8);
                end
                else
                begin
                    st = $urandom_range(2047);
                    sp = $urandom_range(2047);
                end
                if (pick < 85 && sp > WINDOW_DEPTH)
                    sp = WINDOW_DEPTH;
                measure_range(st[INDEX_FIELD_W-1:0], sp[INDEX_FIELD_W-1:0]);
            end
        end
    endtask

    // Overall limit on the run.
    initial
    begin
        #10_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < WINDOW_DEPTH; i++)
            window_store[IDX_W'(i)] = '0;
        oldest_slot = '0;
        mode_shadow = lpc_rwm_pkg::MODE_16;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_range_rules();
        test_sample_extremes();
        test_random_traffic(425, 0, 0);
        test_random_traffic(425, 57, 0);
        test_random_traffic(425, 0, 57);
        test_random_traffic(425, 30, 30);
        wait_for_drain();
        repeat (20) @(posedge clk);

        $display("Sent %0d pushes and %0d measures (%0d bad ranges), %0d result words checked,",
                 push_count, measure_count, bad_range_count, checked_count);
        $display("across all four word_mode settings and four sender/receiver idle patterns.");
        if (fail_count == 0 && pending_measures.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/lpc_rwm_pkg.sv
rtl/lpc_residual_window_measure.sv
rtl/lpc_rwm_checker.sv
verif/testbench.sv
